>>> rtl/mpct_pkg.sv
// shared constants, codes and the job record of the mouse packet cursor tracker
// no dependencies
package mpct_pkg;

  // screen defaults and field widths
  localparam int unsigned DEF_SCREEN_COLS = 80;
  localparam int unsigned DEF_SCREEN_ROWS = 25;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned CELL_W          = 11;
  localparam int unsigned CAUSE_W         = 2;
  localparam int unsigned BTN_IDX_W       = 2;
  localparam int unsigned NUM_BUTTONS     = 3;

  // status bit that flags an auxiliary (mouse) data byte
  localparam int unsigned AUX_READY_BIT = 5;

  // cursor home position, pulled onto the screen when the screen is small
  localparam int unsigned RESET_COL = 40;
  localparam int unsigned RESET_ROW = 12;

  // signed width that holds a coordinate plus a signed byte delta
  localparam int unsigned SUM_W = 10;

  // toggle steps of one packet: old cell, new cell, then one per button
  localparam int unsigned NUM_STEPS  = 5;
  localparam int unsigned STEP_IDX_W = $clog2(NUM_STEPS);
  localparam int unsigned STEP_OLD   = 0;
  localparam int unsigned STEP_NEW   = 1;
  localparam int unsigned STEP_BTN0  = 2;

  // entries of the queue between front and back end
  localparam int unsigned JOB_FIFO_DEPTH = 2;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_OLD    = 2'd0,
    CAUSE_NEW    = 2'd1,
    CAUSE_BUTTON = 2'd2
  } toggle_cause_e;

  typedef enum logic [1:0] {
    POS_BYTE0 = 2'd0,
    POS_BYTE1 = 2'd1,
    POS_BYTE2 = 2'd2
  } byte_pos_e;

  // work handed from the packet decoder to the toggle sequencer
  typedef struct packed {
    logic [NUM_STEPS-1:0] steps;
    logic [CELL_W-1:0]    old_cell;
    logic [CELL_W-1:0]    new_cell;
  } job_t;

endpackage

>>> rtl/mpct_in_if.sv
// input channel: controller status byte and data byte with valid/ready
// depends on mpct_pkg
interface mpct_in_if import mpct_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output status_byte, output data_byte, input ready);
  modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

>>> rtl/mpct_out_if.sv
// output channel: one cell toggle word with valid/ready
// depends on mpct_pkg
interface mpct_out_if import mpct_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CELL_W-1:0]    cell_index;
  logic [CAUSE_W-1:0]   toggle_cause;
  logic [BTN_IDX_W-1:0] button_index;
  logic                 last;

  modport source (output valid, output cell_index, output toggle_cause,
                  output button_index, output last, input ready);
  modport sink   (input valid, input cell_index, input toggle_cause,
                  input button_index, input last, output ready);
endinterface

>>> rtl/mpct_front.sv
// front end: packet assembly, cursor update with clamping, job staging
// depends on mpct_pkg
module mpct_front import mpct_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] status_byte_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              job_valid_o,
  output job_t              job_o,
  input  logic              job_ready_i
);

  localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
  localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
  localparam int unsigned PROD_W = COL_W + ROW_W;
  localparam int unsigned COL_HOME = (RESET_COL > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : RESET_COL;
  localparam int unsigned ROW_HOME = (RESET_ROW > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : RESET_ROW;
  localparam logic [COL_W-1:0] COL_HOME_V = COL_W'(COL_HOME);
  localparam logic [ROW_W-1:0] ROW_HOME_V = ROW_W'(ROW_HOME);
  localparam logic [COL_W-1:0] COL_MAX_V  = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX_V  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic signed [SUM_W-1:0] COL_MAX_S = SUM_W'(SCREEN_COLS - 1);
  localparam logic signed [SUM_W-1:0] ROW_MAX_S = SUM_W'(SCREEN_ROWS - 1);

  byte_pos_e             pos_q, pos_d;
  logic [BYTE_W-1:0]     byte0_q, byte1_q;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [NUM_BUTTONS-1:0] btn_q, btn_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [NUM_STEPS-1:0]  pend_steps_q;
  logic [CELL_W-1:0]     pend_old_q;

  logic                  take, complete, motion;
  logic [NUM_BUTTONS-1:0] btn_chg;
  logic [NUM_STEPS-1:0]  new_steps;
  logic [PROD_W-1:0]     prod;
  logic [CELL_W-1:0]     cur_cell;
  logic signed [SUM_W-1:0] col_sum, row_sum, dx, dy;

  // handshake: stall only while a staged job cannot move on
  assign in_ready_o = !pend_valid_q || job_ready_i;
  assign take       = in_valid_i && in_ready_o && status_byte_i[AUX_READY_BIT];
  assign complete   = take && (pos_q == POS_BYTE2);

  // cell of the cursor as it stands in the registers
  assign prod     = PROD_W'(row_q) * PROD_W'(SCREEN_COLS) + PROD_W'(col_q);
  assign cur_cell = CELL_W'(prod);

  // toggle steps of the packet that completes with this word
  assign motion    = (byte1_q != '0) || (data_byte_i != '0);
  assign btn_chg   = byte0_q[NUM_BUTTONS-1:0] ^ btn_q;
  assign new_steps = {btn_chg, motion, motion};

  // byte position
  always_comb begin
    pos_d = pos_q;
    if (take) begin
      case (pos_q)
        POS_BYTE1: pos_d = POS_BYTE2;
        POS_BYTE2: pos_d = POS_BYTE0;
        default:   pos_d = POS_BYTE1;
      endcase
    end
  end

  // signed sums and clamping to the screen
  always_comb begin
    dx      = {{(SUM_W-BYTE_W){byte1_q[BYTE_W-1]}}, byte1_q};
    dy      = {{(SUM_W-BYTE_W){data_byte_i[BYTE_W-1]}}, data_byte_i};
    col_sum = {{(SUM_W-COL_W){1'b0}}, col_q} + dx;
    row_sum = {{(SUM_W-ROW_W){1'b0}}, row_q} - dy;
    col_d   = col_q;
    row_d   = row_q;
    btn_d   = btn_q;
    if (complete) begin
      if (col_sum[SUM_W-1])      col_d = '0;
      else if (col_sum > COL_MAX_S) col_d = COL_MAX_V;
      else                       col_d = col_sum[COL_W-1:0];
      if (row_sum[SUM_W-1])      row_d = '0;
      else if (row_sum > ROW_MAX_S) row_d = ROW_MAX_V;
      else                       row_d = row_sum[ROW_W-1:0];
      btn_d = byte0_q[NUM_BUTTONS-1:0];
    end
  end

  // staging register: holds a job until its new cell is known and the queue takes it
  always_comb begin
    pend_valid_d = pend_valid_q && !job_ready_i;
    if (complete) pend_valid_d = |new_steps;
  end

  assign job_valid_o    = pend_valid_q;
  assign job_o.steps    = pend_steps_q;
  assign job_o.old_cell = pend_old_q;
  assign job_o.new_cell = cur_cell;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_BYTE0;
      col_q        <= COL_HOME_V;
      row_q        <= ROW_HOME_V;
      btn_q        <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      col_q        <= col_d;
      row_q        <= row_d;
      btn_q        <= btn_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // packet bytes and staged job payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      case (pos_q)
        POS_BYTE1: byte1_q <= data_byte_i;
        POS_BYTE2: begin
          pend_steps_q <= new_steps;
          pend_old_q   <= cur_cell;
        end
        default:   byte0_q <= data_byte_i;
      endcase
    end
  end

endmodule

>>> rtl/mpct_job_fifo.sv
// short job queue between the packet decoder and the toggle sequencer
// depends on mpct_pkg
module mpct_job_fifo import mpct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  job_t in_job_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output job_t out_job_o
);

  localparam int unsigned DEPTH = JOB_FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != CNT_FULL);
  assign out_valid_o = (cnt_q != '0);
  assign out_job_o   = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_job_i;
  end

endmodule

>>> rtl/mpct_back.sv
// back end: steps through the toggles of one job into an output register
// depends on mpct_pkg
module mpct_back import mpct_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  job_t                 job_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CELL_W-1:0]    cell_index_o,
  output toggle_cause_e        toggle_cause_o,
  output logic [BTN_IDX_W-1:0] button_index_o,
  output logic                 last_o
);

  logic [NUM_STEPS-1:0]  steps_q, steps_d, rest, low_oh;
  logic [CELL_W-1:0]     old_cell_q, new_cell_q;
  logic [STEP_IDX_W-1:0] sel;
  logic                  have, can_emit, emit, pop;

  logic                  out_valid_q, out_valid_d;
  logic [CELL_W-1:0]     cell_q, cell_d;
  toggle_cause_e         cause_q, cause_d;
  logic [BTN_IDX_W-1:0]  btn_idx_q, btn_idx_d;
  logic                  last_q, last_d;

  // lowest pending step goes next
  always_comb begin
    sel = '0;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      if (steps_q[i]) sel = STEP_IDX_W'(i);
    end
  end

  assign low_oh   = NUM_STEPS'(1) << sel;
  assign rest     = steps_q & ~low_oh;
  assign have     = |steps_q;
  assign can_emit = !out_valid_q || out_ready_i;
  assign emit     = have && can_emit;

  // fetch the next job as the current one hands out its final toggle
  assign job_ready_o = !have || (emit && (rest == '0));
  assign pop         = job_valid_i && job_ready_o;

  always_comb begin
    steps_d = steps_q;
    if (emit) steps_d = rest;
    if (pop)  steps_d = job_i.steps;
  end

  // output word for the selected step
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    cell_d      = cell_q;
    cause_d     = cause_q;
    btn_idx_d   = btn_idx_q;
    last_d      = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      last_d      = (rest == '0);
      if (sel == STEP_IDX_W'(STEP_OLD)) begin
        cell_d    = old_cell_q;
        cause_d   = CAUSE_OLD;
        btn_idx_d = '0;
      end else if (sel == STEP_IDX_W'(STEP_NEW)) begin
        cell_d    = new_cell_q;
        cause_d   = CAUSE_NEW;
        btn_idx_d = '0;
      end else begin
        cell_d    = new_cell_q;
        cause_d   = CAUSE_BUTTON;
        btn_idx_d = BTN_IDX_W'(sel - STEP_IDX_W'(STEP_BTN0));
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign cell_index_o   = cell_q;
  assign toggle_cause_o = cause_q;
  assign button_index_o = btn_idx_q;
  assign last_o         = last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job cells and output payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      old_cell_q <= job_i.old_cell;
      new_cell_q <= job_i.new_cell;
    end
    cell_q    <= cell_d;
    cause_q   <= cause_d;
    btn_idx_q <= btn_idx_d;
    last_q    <= last_d;
  end

  // old-cell toggle is always followed at once by the new-cell toggle
  a_old_then_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && (cause_q == CAUSE_OLD)
    |=> out_valid_q && (cause_q == CAUSE_NEW))
    else $error("old-cell toggle not followed by new-cell toggle");

  // an old-cell toggle never closes a packet
  a_old_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (cause_q == CAUSE_OLD) |-> !last_q)
    else $error("old-cell toggle marked last");

  // button index only carries meaning on button toggles
  a_btn_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (cause_q != CAUSE_BUTTON) |-> (btn_idx_q == '0))
    else $error("button index set on a motion toggle");

  // the front end never queues a job without toggles
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (job_i.steps != '0))
    else $error("empty job taken from the queue");

endmodule

>>> rtl/mouse_packet_cursor_tracker.sv
// Mouse packet cursor tracker. Accepts one status/data word per cycle; words
// whose status has the aux-data bit set are collected into three-byte mouse
// packets. When a packet completes, the front end moves the text cursor
// (column plus signed x delta, row minus signed y delta, each clamped to the
// screen) and hands a job to a two-entry queue. The back end turns each job
// into up to five cell-toggle words: old cell and new cell when there is
// motion, then one per changed button, with last set on the final one. Words
// leave one per cycle from a single output register while the receiver is ready,
// and that output register sets the worst-case sustained rate. The input side
// stalls only while the staging register and the job queue are both full.
// depends on mpct_pkg, mpct_in_if, mpct_out_if, mpct_front, mpct_job_fifo, mpct_back
module mouse_packet_cursor_tracker import mpct_pkg::*; #(
  parameter int unsigned SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int unsigned SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mpct_in_if.sink     in_i,
  mpct_out_if.source  out_o
);

  logic          front_job_valid, front_job_ready;
  job_t          front_job;
  logic          back_job_valid, back_job_ready;
  job_t          back_job;
  toggle_cause_e cause;

  // packet decoder and cursor update
  mpct_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .status_byte_i (in_i.status_byte),
    .data_byte_i   (in_i.data_byte),
    .job_valid_o   (front_job_valid),
    .job_o         (front_job),
    .job_ready_i   (front_job_ready)
  );

  // job queue
  mpct_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_job_valid),
    .in_ready_o  (front_job_ready),
    .in_job_i    (front_job),
    .out_valid_o (back_job_valid),
    .out_ready_i (back_job_ready),
    .out_job_o   (back_job)
  );

  // toggle sequencer
  mpct_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (back_job_valid),
    .job_ready_o    (back_job_ready),
    .job_i          (back_job),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .cell_index_o   (out_o.cell_index),
    .toggle_cause_o (cause),
    .button_index_o (out_o.button_index),
    .last_o         (out_o.last)
  );

  assign out_o.toggle_cause = cause;

endmodule

>>> verif/mouse_packet_cursor_tracker_tb.sv
// self-checking testbench for the mouse packet cursor tracker: random bursts of
// status/data words in, cell toggle words checked against a packet decoder model
// depends on mpct_pkg, mpct_in_if, mpct_out_if and mouse_packet_cursor_tracker
module mouse_packet_cursor_tracker_tb;
  import mpct_pkg::*;

  localparam int unsigned COLS        = DEF_SCREEN_COLS;
  localparam int unsigned ROWS        = DEF_SCREEN_ROWS;
  localparam int unsigned NUM_WORDS   = 210;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam logic [7:0]  AUX_MASK    = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] data;
  } mouse_word_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_idx;
    toggle_cause_e        cause;
    logic [BTN_IDX_W-1:0] btn;
    logic                 last;
  } toggle_t;

  logic clk_i;
  logic rst_ni;

  mpct_in_if  in_if ();
  mpct_out_if out_if ();

  mouse_packet_cursor_tracker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // words waiting to be sent and toggles waiting to come out
  mouse_word_t pending_words[$];
  toggle_t     expected_toggles[$];

  // decoder model state
  logic [BYTE_W-1:0] pkt_bytes[3];
  int                pkt_pos;
  int                cur_col;
  int                cur_row;
  logic [2:0]        btn_state;

  int err_count;
  int words_in;
  int toggles_out;
  int packets_done;
  int aux_count;
  int idle_cycles;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(int c, int r);
    return CELL_W'(r * int'(COLS) + c);
  endfunction

  // decode one accepted word and queue the toggles it causes
  task automatic predict_word(mouse_word_t w);
    toggle_t tq[$];
    int      dx;
    int      dy;
    if (!w.status[AUX_READY_BIT]) return;
    pkt_bytes[pkt_pos] = w.data;
    pkt_pos = (pkt_pos + 1) % 3;
    if (pkt_pos != 0) return;
    packets_done++;
    // motion: remove old cursor, move with clamping, draw new one
    if (pkt_bytes[1] != '0 || pkt_bytes[2] != '0) begin
      tq.push_back('{cell_idx: cell_of(cur_col, cur_row), cause: CAUSE_OLD, btn: '0,
                     last: 1'b0});
      dx = int'($signed(pkt_bytes[1]));
      dy = int'($signed(pkt_bytes[2]));
      cur_col = clamp_to(cur_col + dx, int'(COLS) - 1);
      cur_row = clamp_to(cur_row - dy, int'(ROWS) - 1);
      tq.push_back('{cell_idx: cell_of(cur_col, cur_row), cause: CAUSE_NEW, btn: '0,
                     last: 1'b0});
    end
    // one toggle per changed button
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (pkt_bytes[0][i] != btn_state[i])
        tq.push_back('{cell_idx: cell_of(cur_col, cur_row), cause: CAUSE_BUTTON,
                       btn: BTN_IDX_W'(i), last: 1'b0});
    end
    btn_state = pkt_bytes[0][2:0];
    if (tq.size() > 0) tq[tq.size()-1].last = 1'b1;
    foreach (tq[k]) expected_toggles.push_back(tq[k]);
  endtask

  // stimulus helpers
  task automatic add_aux(logic [7:0] data);
    pending_words.push_back('{status: 8'($urandom) | AUX_MASK, data: data});
    aux_count++;
  endtask

  task automatic add_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    add_aux(b0);
    add_aux(b1);
    add_aux(b2);
  endtask

  task automatic add_noise();
    pending_words.push_back('{status: 8'($urandom) & ~AUX_MASK, data: 8'($urandom)});
  endtask

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3, 4:    return 8'($signed($urandom_range(0, 10)) - 5);
      default: return 8'($urandom);
    endcase
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin : drv
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_word(pending_words.pop_front());
        words_in++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the word until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid       <= 1'b1;
        in_if.status_byte <= pending_words[0].status;
        in_if.data_byte   <= pending_words[0].data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: ready steps through a 16-bit mask that is picked anew at the start of every pass
  logic [15:0] ready_mask;
  int          mask_pos;

  always @(posedge clk_i) begin : mon
    toggle_t exp_t;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      ready_mask = '1;
      mask_pos   = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        toggles_out++;
        if (expected_toggles.size() == 0) begin
          $error("unexpected toggle word: cell_index %0d toggle_cause %0d",
                 out_if.cell_index, out_if.toggle_cause);
          err_count++;
        end else begin
          exp_t = expected_toggles.pop_front();
          if (out_if.cell_index !== exp_t.cell_idx) begin
            $error("cell_index mismatch: expected %0d, actual %0d", exp_t.cell_idx,
                   out_if.cell_index);
            err_count++;
          end
          if (out_if.toggle_cause !== exp_t.cause) begin
            $error("toggle_cause mismatch: expected %0d, actual %0d", exp_t.cause,
                   out_if.toggle_cause);
            err_count++;
          end
          if (out_if.button_index !== exp_t.btn) begin
            $error("button_index mismatch: expected %0d, actual %0d", exp_t.btn,
                   out_if.button_index);
            err_count++;
          end
          if (out_if.last !== exp_t.last) begin
            $error("last mismatch: expected %0d, actual %0d", exp_t.last, out_if.last);
            err_count++;
          end
        end
      end
      if (mask_pos == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    ready_mask = '1;
          2:       ready_mask = 16'($urandom);
          3:       ready_mask = 16'($urandom) & 16'($urandom);
          default: ready_mask = 16'hFF00;
        endcase
      end
      out_if.ready <= ready_mask[mask_pos];
      mask_pos = (mask_pos + 1) % 16;
    end
  end

  // watchdog on cycles without progress while work is outstanding
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (pending_words.size() == 0 && expected_toggles.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("mouse_packet_cursor_tracker_tb: done, errors");
        $finish;
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    logic [7:0] b0;
    logic [2:0] last_btn;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.status_byte  = '0;
    in_if.data_byte    = '0;
    out_if.ready       = 1'b0;
    pkt_bytes[0]       = '0;
    pkt_bytes[1]       = '0;
    pkt_bytes[2]       = '0;
    pkt_pos            = 0;
    cur_col            = clamp_to(RESET_COL, int'(COLS) - 1);
    cur_row            = clamp_to(RESET_ROW, int'(ROWS) - 1);
    btn_state          = '0;
    err_count          = 0;
    words_in           = 0;
    toggles_out        = 0;
    packets_done       = 0;
    aux_count          = 0;
    idle_cycles        = 0;
    burst_left         = 0;
    gap_left           = 0;
    last_btn           = '0;

    // directed: ignored words, extreme deltas, clamping on all edges,
    // all buttons changing, no-motion packets, sign/overflow bits set
    pending_words.push_back('{status: 8'hDF, data: 8'hFF});
    pending_words.push_back('{status: 8'h00, data: 8'h00});
    add_packet(8'h07, 8'h7F, 8'h80);
    add_packet(8'h00, 8'h00, 8'h00);
    add_packet(8'h00, 8'h00, 8'h00);
    add_packet(8'hF8, 8'h80, 8'h7F);
    add_aux(8'h02);
    pending_words.push_back('{status: 8'h1F, data: 8'h55});
    add_aux(8'h01);
    add_aux(8'hFF);
    add_packet(8'h02, 8'h00, 8'h01);

    // random: mostly whole packets, some noise and stray bytes
    while (pending_words.size() < NUM_WORDS) begin
      case ($urandom_range(0, 9))
        0: add_noise();
        1: add_aux(8'($urandom));
        default: begin
          b0 = 8'($urandom);
          if ($urandom_range(0, 1)) b0[2:0] = last_btn;
          last_btn = b0[2:0];
          add_packet(b0, pick_delta(), pick_delta());
        end
      endcase
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() != 0 || expected_toggles.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d words sent (%0d mouse bytes), %0d packets decoded, %0d toggle words checked",
             words_in, aux_count, packets_done, toggles_out);
    if (err_count == 0) begin
      $display("mouse_packet_cursor_tracker_tb: done, clean");
    end else begin
      $display("mouse_packet_cursor_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mpct_pkg.sv
rtl/mpct_in_if.sv
rtl/mpct_out_if.sv
rtl/mpct_front.sv
rtl/mpct_job_fifo.sv
rtl/mpct_back.sv
rtl/mouse_packet_cursor_tracker.sv
verif/mouse_packet_cursor_tracker_tb.sv
